// File: sv/ln_float_odd_series_assert.svh
// ----------------------------------------------------------------------------
// ln_float_odd_series assertion macros
// Implication checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LN_FLOAT_ODD_SERIES_ASSERT_SVH
`define LN_FLOAT_ODD_SERIES_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LNF_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`define LNF_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define LNF_ASSERT_IMP(lbl, cond, prop, msg)
`define LNF_ASSERT_NXT(lbl, cond, prop, msg)
`endif
`endif

// File: sv/lnf_pkg.sv
// ----------------------------------------------------------------------------
// lnf_pkg
// Shared types and constants of the float32 natural log pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package lnf_pkg;
  typedef struct packed {
    logic        spec;
    logic [31:0] sres;
    logic        dom;
    logic        kneg;
    logic [7:0]  kabs;
    logic        zneg;
  } info_t;

  localparam logic [23:0] SQRT2_SIG  = 24'd11863284;
  localparam logic [63:0] LN2_FRAC64 = 64'hB17217F7D1CF79AB;
  localparam logic [31:0] NEG_INF    = 32'hFF800000;
  localparam logic [31:0] POS_INF    = 32'h7F800000;
  localparam logic [31:0] QNAN_BIT   = 32'h00400000;
endpackage
`default_nettype wire

// File: sv/ln_float_odd_series.sv
// Throughput: one word per cycle; the FRAC_BITS + 1 bit divider stages and
// six two-stage multipliers all advance together on one enable.
// A stalled output freezes every stage; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data regs keep values.
// ----------------------------------------------------------------------------
// ln_float_odd_series
// Pipelined float32 natural log: z=(x-1)/(x+1), odd series in z, plus k*ln2.
// ----------------------------------------------------------------------------
`default_nettype none
module ln_float_odd_series #(
  parameter int FRAC_BITS = 30
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] arg_bits
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] result_bits
  output logic [0:0]       out_tuser   // [0] domain_error
);
  import lnf_pkg::*;
  `include "ln_float_odd_series_assert.svh"

  localparam int F  = FRAC_BITS;
  localparam int W  = F + 2;
  localparam int M  = F + 9;
  localparam int PW = $clog2(M);
  localparam int IW = $bits(info_t);
  localparam logic [63:0] TWO = 64'd1 << (F + 1);
  localparam logic [W-1:0] CF [5] = '{
    W'((TWO + 64'd0) / 64'd1), W'((TWO + 64'd1) / 64'd3), W'((TWO + 64'd2) / 64'd5),
    W'((TWO + 64'd3) / 64'd7), W'((TWO + 64'd4) / 64'd9)};
  localparam logic [64:0] LN2F = ({1'b0, LN2_FRAC64} + (65'd1 << (63 - F))) >> (64 - F);

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // decode
  logic [7:0]  ef;
  logic [22:0] mf;
  logic [4:0]  b;
  logic [23:0] sig;
  logic signed [9:0] e2, kk;
  logic        ge2, nan, dz, zn;
  logic [W-1:0] x, one;
  info_t       inf_d;

  always_comb begin
    ef = in_tdata[30:23];
    mf = in_tdata[22:0];
    b  = '0;
    for (int i = 0; i < 23; i++) begin
      if (mf[i]) b = 5'(i);
    end
    if (ef == 8'd0) begin
      sig = 24'(mf) << (5'd23 - b);
      e2  = 10'(b) - 10'sd149;
    end else begin
      sig = {1'b1, mf};
      e2  = 10'(ef) - 10'sd127;
    end
    ge2 = sig >= SQRT2_SIG;
    kk  = ge2 ? e2 + 10'sd1 : e2;
    x   = ge2 ? W'(sig) << (F - 24) : W'(sig) << (F - 23);
    one = W'(1) << F;
    zn  = x < one;
    nan = (ef == 8'hFF) && (mf != '0);
    dz  = (in_tdata[30:0] == '0) || in_tdata[31];
    inf_d.spec = nan || dz || (ef == 8'hFF);
    inf_d.sres = nan ? (in_tdata | QNAN_BIT) : (dz ? NEG_INF : POS_INF);
    inf_d.dom  = !nan && dz;
    inf_d.kneg = kk < 0;
    inf_d.kabs = kk < 0 ? 8'(-kk) : 8'(kk);
    inf_d.zneg = zn;
  end

  logic         vld0_r;
  info_t        info0_r;
  logic [W-1:0] num0_r, den0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      info0_r <= inf_d;
      num0_r  <= zn ? one - x : x - one;
      den0_r  <= x + one;
    end
  end

  // divide
  logic         vd;
  logic [F:0]   q;
  logic [IW-1:0] sd;
  logic [W-1:0] z;

  lnf_div #(.F(F), .SW(IW)) u_div (
    .clk, .rst_n, .en, .vld_i(vld0_r), .num_i(num0_r), .den_i(den0_r),
    .side_i(info0_r), .vld_o(vd), .q_o(q), .side_o(sd));

  assign z = W'(({1'b0, q} + (F + 2)'(1)) >> 1);

  // z squared
  logic            vz;
  logic [W-1:0]    z2;
  logic [IW+W-1:0] sz;

  lnf_mul #(.F(F), .W(W), .SW(IW + W)) u_sq (
    .clk, .rst_n, .en, .vld_i(vd), .a_i(z), .b_i(z), .c_i('0),
    .side_i({sd, z}), .vld_o(vz), .p_o(z2), .side_o(sz));

  // Horner chain over z^2
  logic [W-1:0]      pl [5];
  logic [IW+2*W-1:0] sp [5];
  logic              vp [5];

  assign pl[0] = CF[4];
  assign sp[0] = {sz, z2};
  assign vp[0] = vz;

  for (genvar j = 0; j < 4; j++) begin : g_poly
    lnf_mul #(.F(F), .W(W), .SW(IW + 2 * W)) u_pm (
      .clk, .rst_n, .en, .vld_i(vp[j]), .a_i(pl[j]), .b_i(sp[j][W-1:0]),
      .c_i(CF[3-j]), .side_i(sp[j]), .vld_o(vp[j+1]), .p_o(pl[j+1]),
      .side_o(sp[j+1]));
  end

  // t = z * poly
  logic          vt;
  logic [W-1:0]  t;
  logic [IW-1:0] st;

  lnf_mul #(.F(F), .W(W), .SW(IW)) u_tm (
    .clk, .rst_n, .en, .vld_i(vp[4]), .a_i(pl[4]), .b_i(sp[4][2*W-1:W]),
    .c_i('0), .side_i(sp[4][IW+2*W-1:2*W]), .vld_o(vt), .p_o(t), .side_o(st));

  // k*ln2 +- t
  info_t        ti;
  logic [M-1:0] kp;
  logic         sub;
  assign ti  = info_t'(st);
  assign kp  = M'(ti.kabs) * M'(LN2F);
  assign sub = (!ti.kneg && ti.kabs != '0 && ti.zneg) || (ti.kneg && !ti.zneg);

  logic         vm_r, vl_r, vs_r, out_vld_r;
  info_t        im_r, il_r, is_r;
  logic [M-1:0] m_r, ml_r, nm_r;
  logic [PW-1:0] pl_r, ps_r;
  logic         zl_r, zs_r;
  logic [PW-1:0] pf;
  logic [31:0]  out_data_r;
  logic         out_dom_r;

  always_comb begin
    pf = '0;
    for (int i = 0; i < M; i++) begin
      if (m_r[i]) pf = PW'(i);
    end
  end

  // round to nearest even and pack
  logic [23:0] mt;
  logic [24:0] mr;
  logic        half, sticky, rnd, ng;
  logic [22:0] frac;
  logic [7:0]  ex;
  logic [31:0] res;

  always_comb begin
    mt     = nm_r[M-1:M-24];
    half   = nm_r[M-25];
    sticky = |nm_r[M-26:0];
    rnd    = half && (sticky || mt[0]);
    mr     = {1'b0, mt} + 25'(rnd);
    frac   = mr[24] ? mr[23:1] : mr[22:0];
    ex     = 8'(int'(ps_r) + int'(mr[24]) + 127 - F);
    ng     = is_r.kneg || (is_r.kabs == '0 && is_r.zneg);
    if (is_r.spec) begin
      res = is_r.sres;
    end else if (zs_r) begin
      res = '0;
    end else begin
      res = {ng, ex, frac};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r      <= 1'b0;
      vl_r      <= 1'b0;
      vs_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vm_r      <= vt;
      vl_r      <= vm_r;
      vs_r      <= vl_r;
      out_vld_r <= vs_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      im_r       <= ti;
      m_r        <= sub ? kp - M'(t) : kp + M'(t);
      il_r       <= im_r;
      ml_r       <= m_r;
      pl_r       <= pf;
      zl_r       <= m_r == '0;
      is_r       <= il_r;
      nm_r       <= ml_r << (PW'(M - 1) - pl_r);
      ps_r       <= pl_r;
      zs_r       <= zl_r;
      out_data_r <= res;
      out_dom_r  <= is_r.dom;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_dom_r;

  `LNF_ASSERT_IMP(a_dom_ninf, out_tvalid && out_tuser[0], out_tdata == NEG_INF, "domain word not -inf")
  `LNF_ASSERT_NXT(a_accept_vld, in_tvalid && in_tready, vld0_r, "accepted word lost at entry")
  `LNF_ASSERT_NXT(a_stall_hold, !in_tready, $stable(vld0_r) && $stable(vs_r), "pipeline moved in stall")
endmodule
`default_nettype wire

// File: sv/lnf_div.sv
// ----------------------------------------------------------------------------
// lnf_div
// Restoring fixed-point divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none
module lnf_div #(
  parameter int F  = 30,
  parameter int SW = 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         vld_i,
  input  wire logic [F+1:0] num_i,
  input  wire logic [F+1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic              vld_o,
  output logic [F:0]        q_o,
  output logic [SW-1:0]     side_o
);
  localparam int N = F + 1;

  logic [F+2:0]  rem_r  [N];
  logic [F:0]    q_r    [N];
  logic [F+1:0]  den_r  [N];
  logic [SW-1:0] side_r [N];
  logic          vld_r  [N];

  for (genvar i = 0; i < N; i++) begin : g_stg
    logic [F+2:0]  rem_in, trial, rem_nxt;
    logic [F:0]    q_in, q_nxt;
    logic [F+1:0]  den_in;
    logic [SW-1:0] side_in;
    logic          vld_in, ge;
    if (i == 0) begin : g_first
      assign rem_in  = {1'b0, num_i};
      assign q_in    = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign q_in    = q_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end
    assign trial   = {rem_in[F+1:0], 1'b0};
    assign ge      = trial >= {1'b0, den_in};
    assign rem_nxt = ge ? trial - {1'b0, den_in} : trial;
    assign q_nxt   = {q_in[F-1:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        q_r[i]    <= q_nxt;
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[N-1];
  assign q_o    = q_r[N-1];
  assign side_o = side_r[N-1];
endmodule
`default_nettype wire

// File: sv/lnf_mul.sv
// ----------------------------------------------------------------------------
// lnf_mul
// Two-stage fixed-point multiply-add: split partial products, then sum,
// round half up to F fraction bits and add a constant.
// ----------------------------------------------------------------------------
`default_nettype none
module lnf_mul #(
  parameter int F  = 30,
  parameter int W  = 32,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_i,
  input  wire logic [W-1:0]  a_i,
  input  wire logic [W-1:0]  b_i,
  input  wire logic [W-1:0]  c_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic [W-1:0]       p_o,
  output logic [SW-1:0]      side_o
);
  localparam int H  = (W + 1) / 2;
  localparam int SM = 4 * H + 3;

  logic [H-1:0]   a0, a1, b0, b1;
  logic [2*H-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [W-1:0]   c_r, p_r;
  logic [SW-1:0]  side1_r, side2_r;
  logic           vld1_r, vld2_r;
  logic [SM-1:0]  sum;

  assign a0 = a_i[H-1:0];
  assign b0 = b_i[H-1:0];
  assign a1 = H'(a_i[W-1:H]);
  assign b1 = H'(b_i[W-1:H]);

  assign sum = (SM'(pp11_r) << (2 * H)) + ((SM'(pp01_r) + SM'(pp10_r)) << H)
             + SM'(pp00_r) + (SM'(1) << (F - 1)) + (SM'(c_r) << F);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r  <= a0 * b0;
      pp01_r  <= a0 * b1;
      pp10_r  <= a1 * b0;
      pp11_r  <= a1 * b1;
      c_r     <= c_i;
      side1_r <= side_i;
      p_r     <= W'(sum >> F);
      side2_r <= side1_r;
    end
  end

  assign vld_o  = vld2_r;
  assign p_o    = p_r;
  assign side_o = side2_r;
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams float32 words through the natural log pipeline and compares each
// result word and domain flag against a fixed-point predictor of the series.
// ----------------------------------------------------------------------------
`default_nettype none

class ln_scoreboard;
  logic [32:0] pending_ln[$];
  int          n_errors;

  function new();
    n_errors = 0;
  endfunction

  static function logic [63:0] round_mul(logic [63:0] a, logic [63:0] b, int fb);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (fb - 1));
    return 64'(p >> fb);
  endfunction

  static function logic [63:0] series_coef(int j, int fb);
    logic [63:0] d;
    d = 64'(2 * j + 1);
    return ((64'd1 << (fb + 1)) + d / 2) / d;
  endfunction

  // returns {domain_error, result_bits}
  static function logic [32:0] ln_of(logic [31:0] a, int fb);
    logic [7:0]   ef;
    logic [22:0]  mf;
    logic [63:0]  sig, x, one, num, den, rem, q, z, z2, poly, t, ln2f, mant;
    logic [127:0] m, h, back;
    int           e2, k, p, b, s;
    bit           zneg, neg, half, sticky;
    ef = a[30:23];
    mf = a[22:0];
    if (ef == 8'hFF && mf != 0) return {1'b0, a | lnf_pkg::QNAN_BIT};
    if (a[30:0] == 0 || a[31]) return {1'b1, lnf_pkg::NEG_INF};
    if (ef == 8'hFF) return {1'b0, lnf_pkg::POS_INF};
    if (ef == 0) begin
      b = 22;
      while (b > 0 && !mf[b]) b--;
      sig = 64'(mf) << (23 - b);
      e2 = b - 149;
    end else begin
      sig = 64'(mf) | 64'h800000;
      e2 = int'(ef) - 127;
    end
    if (sig >= 64'(lnf_pkg::SQRT2_SIG)) begin
      x = sig << (fb - 24);
      k = e2 + 1;
    end else begin
      x = sig << (fb - 23);
      k = e2;
    end
    one = 64'd1 << fb;
    zneg = x < one;
    num = zneg ? one - x : x - one;
    den = x + one;
    rem = num;
    q = 0;
    for (int i = 0; i < fb + 1; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    z = (q + 1) >> 1;
    z2 = round_mul(z, z, fb);
    poly = series_coef(4, fb);
    for (int i = 3; i >= 0; i--) poly = round_mul(poly, z2, fb) + series_coef(i, fb);
    t = round_mul(poly, z, fb);
    ln2f = (lnf_pkg::LN2_FRAC64 + (64'd1 << (63 - fb))) >> (64 - fb);
    m = 128'(64'(k < 0 ? -k : k)) * 128'(ln2f);
    if ((k > 0 && zneg) || (k < 0 && !zneg)) m = m - 128'(t);
    else m = m + 128'(t);
    neg = (k < 0) || (k == 0 && zneg);
    if (m == 0) return 33'd0;
    p = 127;
    while (p > 0 && !m[p]) p--;
    if (p > 23) begin
      s = p - 23;
      h = m >> (s - 1);
      back = h << (s - 1);
      mant = 64'(m >> s);
      half = h[0];
      sticky = back != m;
      if (half && (sticky || mant[0])) mant++;
      if (mant >= (64'd1 << 24)) begin
        mant = mant >> 1;
        p++;
      end
    end else begin
      mant = 64'(m) << (23 - p);
    end
    return {1'b0, neg, 8'(p - fb + 127), mant[22:0]};
  endfunction

  function void note_arg(logic [31:0] a, int fb);
    pending_ln.push_back(ln_of(a, fb));
  endfunction

  function void check_result(logic [31:0] res, logic dom);
    logic [32:0] e;
    if (pending_ln.size() == 0) begin
      $error("unexpected result word %h", res);
      n_errors++;
      return;
    end
    e = pending_ln.pop_front();
    if (res !== e[31:0]) begin
      $error("result_bits: expected %h, actual %h", e[31:0], res);
      n_errors++;
    end
    if (dom !== e[32]) begin
      $error("domain_error: expected %b, actual %b", e[32], dom);
      n_errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 30;
  localparam int LATENCY = FB + 18;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;

  int src_idle = 0;
  int sink_stall = 0;

  ln_scoreboard board = new();

  ln_float_odd_series #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser[0]);
    out_tready <= ($urandom_range(99) >= sink_stall);
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_word(logic [31:0] a);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= a;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_arg(a, FB);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending_ln.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_arg();
    logic [31:0] a;
    a = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: a[31] = 1'b0;
      4: a[30:23] = 8'd0;
      5: a[30:23] = 8'd127 - 8'($urandom_range(1));
      6: a = {1'b0, 8'd127, 23'($urandom_range(8)) | (a[22:0] & 23'h7FFF00)};
      7: a[30:23] = 8'hFF;
      default: ;
    endcase
    return a;
  endfunction

  initial begin
    logic [31:0] dir[$];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    dir = '{32'h3F800000, 32'h00000000, 32'h80000000, 32'hBF800000, 32'hFF800000,
            32'h7F800000, 32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF, 32'h00000001,
            32'h007FFFFF, 32'h00400000, 32'h00800000, 32'h7F7FFFFF, 32'h3FB504F4,
            32'h3FB504F3, 32'h3F3504F3, 32'h40000000, 32'h3F000000, 32'h402DF854,
            32'h3F800001, 32'h3F7FFFFF, 32'h55555555, 32'h2AAAAAAA, 32'hFFFFFFFE};
    foreach (dir[i]) send_word(dir[i]);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      src_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 79 : 28) : 0;
      sink_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 79 : 28) : 0;
      for (int n = 0; n < 480; n++) send_word(rand_arg());
      drain();
    end
    src_idle = 0;
    sink_stall = 0;
    repeat (LATENCY + 10) @(posedge clk);
    if (board.n_errors == 0 && board.pending_ln.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/lnf_pkg.sv
sv/lnf_div.sv
sv/lnf_mul.sv
sv/ln_float_odd_series.sv
tb/tb_top.sv
